>>> design/hsvrgba_pkg.sv
// shared constants and types for the hsv to rgba converter
// no dependencies; used by hsvrgba_div255 and hsv_to_rgba_convert
package hsvrgba_pkg;

  localparam int unsigned HUE_W  = 11;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PROD_W = 16;
  localparam int unsigned WIDE_W = 24;
  localparam int unsigned PACK_W = 32;

  // 1.0 in saturation/value units, also the divisor of every term
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;
  // one whole sector in hue fraction units
  localparam logic [BYTE_W:0]   FRAC_ONE = 9'd256;
  // 255 * 256, denominator of the q and t terms
  localparam logic [PROD_W-1:0] FRAC_DEN = 16'd65280;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_t;

endpackage

>>> design/hsv_to_rgba_convert.sv
// hsv to rgba pixel converter, top level with a four-stage pipeline
// depends on hsvrgba_pkg and hsvrgba_div255
//
// Converts one pixel per clock from hue/saturation/value plus alpha into red,
// green and blue bytes and a packed RRGGBBAA word. Hue bits 10..8 pick the
// 60-degree sector (codes 6 and 7 act as sectors 0 and 1), bits 7..0 are the
// fraction within the sector. All terms are truncating integer divisions.
// An accepted input beat passes through stages 1 to 3 into the output register;
// one beat is taken every cycle while the output side is not stalling. The
// four stages are: fraction and saturation products, products with value,
// divide by 255, sector permutation into the output register. Each stage
// holds its beat when the stage after it is full and blocked, so a stall
// on the output ripples back to in_stall in the same cycle once every stage
// is occupied; bubbles are squeezed out while stalled.
module hsv_to_rgba_convert (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hsvrgba_pkg::HUE_W-1:0]       hue,
  input  logic [hsvrgba_pkg::BYTE_W-1:0]      saturation,
  input  logic [hsvrgba_pkg::BYTE_W-1:0]      brightness,
  input  logic [hsvrgba_pkg::BYTE_W-1:0]      alpha,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hsvrgba_pkg::BYTE_W-1:0]      red,
  output logic [hsvrgba_pkg::BYTE_W-1:0]      green,
  output logic [hsvrgba_pkg::BYTE_W-1:0]      blue,
  output logic [hsvrgba_pkg::PACK_W-1:0]      packed_rgba
);

  // stage advance enables, back to front
  logic en1, en2, en3, en4;
  logic v1, v2, v3;

  // stage 1: products of fraction and saturation
  hsvrgba_pkg::sector_t               sec1, sec2, sec3;
  hsvrgba_pkg::sector_t               sec_in;
  logic [hsvrgba_pkg::BYTE_W-1:0]     val1, val2, val3;
  logic [hsvrgba_pkg::BYTE_W-1:0]     a1, a2, a3;
  logic [hsvrgba_pkg::PROD_W-1:0]     pprod1, pprod2;
  logic [hsvrgba_pkg::PROD_W-1:0]     qnum1, tnum1;

  // stage 2: products with value
  logic [hsvrgba_pkg::WIDE_W-1:0]     qprod2, tprod2;

  // stage 3: divided terms
  logic [hsvrgba_pkg::BYTE_W-1:0]     p3, q3, t3;

  // combinational helpers
  logic [hsvrgba_pkg::BYTE_W-1:0]     frac;
  logic [hsvrgba_pkg::BYTE_W:0]       frac_inv;
  logic [hsvrgba_pkg::PROD_W-1:0]     fs;
  logic [hsvrgba_pkg::PROD_W:0]       fts;
  logic [hsvrgba_pkg::PROD_W-1:0]     pprod_next;
  logic [hsvrgba_pkg::WIDE_W-1:0]     qprod_next, tprod_next;
  logic [hsvrgba_pkg::BYTE_W-1:0]     p_div, q_div, t_div;
  logic [hsvrgba_pkg::BYTE_W-1:0]     r_next, g_next, b_next;

  assign en4 = !out_valid || !out_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  // sector decode, codes 6 and 7 wrap back to 0 and 1
  always_comb begin
    unique case (hue[hsvrgba_pkg::HUE_W-1:hsvrgba_pkg::BYTE_W])
      3'd0, 3'd6: sec_in = hsvrgba_pkg::SEC_0;
      3'd1, 3'd7: sec_in = hsvrgba_pkg::SEC_1;
      3'd2:       sec_in = hsvrgba_pkg::SEC_2;
      3'd3:       sec_in = hsvrgba_pkg::SEC_3;
      3'd4:       sec_in = hsvrgba_pkg::SEC_4;
      3'd5:       sec_in = hsvrgba_pkg::SEC_5;
    endcase
  end

  assign frac     = hue[hsvrgba_pkg::BYTE_W-1:0];
  assign frac_inv = hsvrgba_pkg::FRAC_ONE - {1'b0, frac};
  assign fs       = {8'b0, frac} * {8'b0, saturation};
  // (256-f)*s tops out at 65280, so the low 16 bits carry it
  assign fts      = {8'b0, frac_inv} * {9'b0, saturation};
  assign pprod_next = {8'b0, brightness} *
                      {8'b0, hsvrgba_pkg::BYTE_MAX - saturation};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      sec1   <= sec_in;
      val1   <= brightness;
      a1     <= alpha;
      pprod1 <= pprod_next;
      qnum1  <= hsvrgba_pkg::FRAC_DEN - fs;
      tnum1  <= hsvrgba_pkg::FRAC_DEN - fts[hsvrgba_pkg::PROD_W-1:0];
    end
  end

  assign qprod_next = {16'b0, val1} * {8'b0, qnum1};
  assign tprod_next = {16'b0, val1} * {8'b0, tnum1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      sec2   <= sec1;
      val2   <= val1;
      a2     <= a1;
      pprod2 <= pprod1;
      qprod2 <= qprod_next;
      tprod2 <= tprod_next;
    end
  end

  // 65280 = 256 * 255: drop the low byte, then divide by 255
  hsvrgba_div255 u_div_p (
    .dividend (pprod2),
    .quotient (p_div)
  );

  hsvrgba_div255 u_div_q (
    .dividend (qprod2[hsvrgba_pkg::WIDE_W-1:hsvrgba_pkg::BYTE_W]),
    .quotient (q_div)
  );

  hsvrgba_div255 u_div_t (
    .dividend (tprod2[hsvrgba_pkg::WIDE_W-1:hsvrgba_pkg::BYTE_W]),
    .quotient (t_div)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      sec3 <= sec2;
      val3 <= val2;
      a3   <= a2;
      p3   <= p_div;
      q3   <= q_div;
      t3   <= t_div;
    end
  end

  // sector permutation of v, p, q, t
  always_comb begin
    unique case (sec3)
      hsvrgba_pkg::SEC_0: begin
        r_next = val3; g_next = t3;   b_next = p3;
      end
      hsvrgba_pkg::SEC_1: begin
        r_next = q3;   g_next = val3; b_next = p3;
      end
      hsvrgba_pkg::SEC_2: begin
        r_next = p3;   g_next = val3; b_next = t3;
      end
      hsvrgba_pkg::SEC_3: begin
        r_next = p3;   g_next = q3;   b_next = val3;
      end
      hsvrgba_pkg::SEC_4: begin
        r_next = t3;   g_next = p3;   b_next = val3;
      end
      default: begin
        r_next = val3; g_next = p3;   b_next = q3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
    if (en4) begin
      red         <= r_next;
      green       <= g_next;
      blue        <= b_next;
      packed_rgba <= {r_next, g_next, b_next, a3};
    end
  end

`ifndef SYNTHESIS
  // input only backs up when the whole pipe is full behind a blocked output
  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && v1 && v2 && v3))
    else $error("input stalled while the pipeline has room");

  // a beat in the last internal stage reaches the output once it is free
  a_stage3_drains: assert property (
    @(posedge clk) disable iff (rst)
    (v3 && !out_stall) |=> out_valid)
    else $error("stage 3 beat lost on its way to the output");

  // an accepted input beat always lands in stage 1
  a_accept_lands: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted input beat missing from stage 1");
`endif

endmodule

>>> design/hsvrgba_div255.sv
// truncating divide by 255 of a 16-bit value up to 65025
// depends on hsvrgba_pkg for widths and the divisor
module hsvrgba_div255 (
  input  logic [hsvrgba_pkg::PROD_W-1:0] dividend,
  output logic [hsvrgba_pkg::BYTE_W-1:0] quotient
);

  logic [hsvrgba_pkg::WIDE_W-1:0] recip;
  logic [hsvrgba_pkg::BYTE_W-1:0] est;
  logic [hsvrgba_pkg::PROD_W-1:0] back;
  logic [hsvrgba_pkg::PROD_W-1:0] rem;

  // x*257/65536 never overshoots x/255 and undershoots by at most one
  assign recip = {dividend, 8'b0} + {8'b0, dividend};
  assign est   = recip[hsvrgba_pkg::WIDE_W-1:hsvrgba_pkg::PROD_W];
  assign back  = {est, 8'b0} - {8'b0, est};
  assign rem   = dividend - back;

  assign quotient = (rem >= {8'b0, hsvrgba_pkg::BYTE_MAX}) ? est + 8'd1 : est;

endmodule
